// ----- rtl/core/dual_bounded_member_set_assert.svh -----
// assertion macros for the member set block
`ifndef DUAL_BOUNDED_MEMBER_SET_ASSERT_SVH
`define DUAL_BOUNDED_MEMBER_SET_ASSERT_SVH
`ifndef SYNTHESIS
`define DBMS_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define DBMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define DBMS_ASSERT_NOW(lbl, cond, msg)
`define DBMS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/dbms_pkg.sv -----
`default_nettype none
package dbms_pkg;

  localparam int ID_W = 31;
  localparam int POS_W = 6;
  localparam int CNT_OUT_W = 7;
  localparam int ST_W = 3;
  localparam int CMD_W = 2;

  localparam int DEF_FRIEND_DEPTH = 64;
  localparam int DEF_BLOCK_DEPTH = 64;

  localparam logic LIST_BLOCK = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_MEMBER = 3'd1,
    ST_ALREADY    = 3'd2,
    ST_FULL       = 3'd3,
    ST_BAD_POS    = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t             op;
    logic             scan;
    logic             list;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] pos;
  } req_t;

endpackage
`default_nettype wire

// ----- rtl/core/dbms_front.sv -----
`default_nettype none
module dbms_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [dbms_pkg::CMD_W-1:0] command,
  input  wire logic                       which_list,
  input  wire logic [dbms_pkg::ID_W-1:0]  member_id,
  input  wire logic [dbms_pkg::POS_W-1:0] position,
  output dbms_pkg::req_t                  req,
  output logic                            req_valid,
  input  wire logic                       req_take
);

  dbms_pkg::req_t q [2];
  dbms_pkg::req_t in_req;
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic           acc;

  // classify the incoming word
  always_comb begin
    in_req.op   = dbms_pkg::cmd_t'(command);
    in_req.scan = (command != dbms_pkg::CMD_READ);
    in_req.list = which_list;
    in_req.id   = member_id;
    in_req.pos  = position;
  end

  assign full      = (cnt == 2'd2);
  assign acc       = push && !full;
  assign req_valid = (cnt != 2'd0);
  assign req       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (acc) begin
        wp <= ~wp;
      end
      if (req_take) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(acc) - 2'(req_take);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q[wp] <= in_req;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/dbms_back.sv -----
`default_nettype none
module dbms_back #(
  parameter int FRIEND_DEPTH = dbms_pkg::DEF_FRIEND_DEPTH,
  parameter int BLOCK_DEPTH  = dbms_pkg::DEF_BLOCK_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dbms_pkg::req_t                 req,
  input  wire logic                           req_valid,
  output logic                                req_take,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [dbms_pkg::ST_W-1:0]           status,
  output logic [dbms_pkg::ID_W-1:0]           read_value,
  output logic [dbms_pkg::CNT_OUT_W-1:0]      list_count
);

  localparam int MAXD = (FRIEND_DEPTH > BLOCK_DEPTH) ? FRIEND_DEPTH : BLOCK_DEPTH;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int FAW  = (FRIEND_DEPTH > 1) ? $clog2(FRIEND_DEPTH) : 1;
  localparam int BAW  = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int PW   = (CW > dbms_pkg::POS_W) ? CW : dbms_pkg::POS_W;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN_RD  = 7'b0000010,
    S_SCAN_CMP = 7'b0000100,
    S_SHIFT_RD = 7'b0001000,
    S_SHIFT_WR = 7'b0010000,
    S_READ_RD  = 7'b0100000,
    S_READ_CAP = 7'b1000000
  } state_t;

  logic [dbms_pkg::ID_W-1:0] fmem [FRIEND_DEPTH];
  logic [dbms_pkg::ID_W-1:0] bmem [BLOCK_DEPTH];
  logic [dbms_pkg::ID_W-1:0] frd;
  logic [dbms_pkg::ID_W-1:0] brd;
  logic [dbms_pkg::ID_W-1:0] rd;

  state_t state, state_next;
  dbms_pkg::req_t cur;
  logic [CW-1:0] n;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] fused;
  logic [CW-1:0] bused;
  logic [CW-1:0] req_n;
  logic [CW-1:0] dep;
  logic [CW-1:0] rd_addr;
  logic          req_pos_ok;
  logic          take;

  logic                      we;
  logic [CW-1:0]             wa;
  logic [dbms_pkg::ID_W-1:0] wd;

  logic                      fin;
  dbms_pkg::status_t         fin_status;
  logic [dbms_pkg::ID_W-1:0] fin_value;
  logic [CW-1:0]             fin_count;

  logic                      res_valid;
  dbms_pkg::status_t         res_status;
  logic [dbms_pkg::ID_W-1:0] res_value;
  logic [CW-1:0]             res_count;

  assign rd         = (cur.list == dbms_pkg::LIST_BLOCK) ? brd : frd;
  assign dep        = (cur.list == dbms_pkg::LIST_BLOCK) ? CW'(BLOCK_DEPTH) : CW'(FRIEND_DEPTH);
  assign req_n      = (req.list == dbms_pkg::LIST_BLOCK) ? bused : fused;
  assign req_pos_ok = PW'(req.pos) < PW'(req_n);
  assign take       = (state == S_IDLE) && req_valid && !res_valid;
  assign rd_addr    = (state == S_SHIFT_RD) ? idx + CW'(1) : idx;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    fin        = 1'b0;
    fin_status = dbms_pkg::ST_OK;
    fin_value  = '0;
    fin_count  = n;
    we         = 1'b0;
    wa         = idx;
    wd         = rd;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (!req.scan) begin
            if (req_pos_ok) begin
              idx_next   = CW'(req.pos);
              state_next = S_READ_RD;
            end else begin
              fin        = 1'b1;
              fin_status = dbms_pkg::ST_BAD_POS;
              fin_count  = req_n;
            end
          end else begin
            idx_next   = '0;
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx == n) begin
          // id absent from the list
          state_next = S_IDLE;
          fin        = 1'b1;
          unique case (cur.op)
            dbms_pkg::CMD_ADD: begin
              if (n >= dep) begin
                fin_status = dbms_pkg::ST_FULL;
              end else begin
                we        = 1'b1;
                wa        = n;
                wd        = cur.id;
                fin_count = n + CW'(1);
              end
            end
            default: fin_status = dbms_pkg::ST_NOT_MEMBER;
          endcase
        end else begin
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (rd == cur.id) begin
          unique case (cur.op)
            dbms_pkg::CMD_DELETE: state_next = S_SHIFT_RD;
            dbms_pkg::CMD_ADD: begin
              state_next = S_IDLE;
              fin        = 1'b1;
              fin_status = dbms_pkg::ST_ALREADY;
            end
            default: begin
              state_next = S_IDLE;
              fin        = 1'b1;
            end
          endcase
        end else begin
          idx_next   = idx + CW'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (idx + CW'(1) == n) begin
          state_next = S_IDLE;
          fin        = 1'b1;
          fin_count  = n - CW'(1);
        end else begin
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we         = 1'b1;
        wa         = idx;
        wd         = rd;
        idx_next   = idx + CW'(1);
        state_next = S_SHIFT_RD;
      end
      S_READ_RD: begin
        state_next = S_READ_CAP;
      end
      S_READ_CAP: begin
        state_next = S_IDLE;
        fin        = 1'b1;
        fin_value  = rd;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // entry stores, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (we && cur.list != dbms_pkg::LIST_BLOCK) begin
      fmem[wa[FAW-1:0]] <= wd;
    end
    frd <= fmem[rd_addr[FAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we && cur.list == dbms_pkg::LIST_BLOCK) begin
      bmem[wa[BAW-1:0]] <= wd;
    end
    brd <= bmem[rd_addr[BAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fused     <= '0;
      bused     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (fin) begin
        res_valid <= 1'b1;
      end
      if (fin && state != S_IDLE) begin
        if (cur.list == dbms_pkg::LIST_BLOCK) begin
          bused <= fin_count;
        end else begin
          fused <= fin_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= req;
      n   <= req_n;
    end
    idx <= idx_next;
    if (fin) begin
      res_status <= fin_status;
      res_value  <= fin_value;
      res_count  <= fin_count;
    end
  end

  assign req_take   = take;
  assign empty      = !res_valid;
  assign status     = res_status;
  assign read_value = res_value;
  assign list_count = dbms_pkg::CNT_OUT_W'(res_count);

endmodule
`default_nettype wire

// ----- rtl/core/dual_bounded_member_set.sv -----
// Two independent member lists (friend and block), each packed from entry 0 with
// its own count. Requests enter through a two-word queue and results leave through
// a one-word result register; while a result waits the back end stalls, and full
// rises once two more requests have queued behind it. Requests run one at a time in
// the back end, whose entry stores have one registered read port each: check, add
// and delete scan the selected list, reading each entry and then comparing it with
// the id, and a hit ends a check or add; a delete that hits goes on to compact the
// later entries, reading each one and writing it one place lower. A read reads the
// entry at its position and then captures it; a read whose position is not below
// the count is rejected without reading. Entry stores are not cleared at reset;
// only entries below the count are read.
`default_nettype none
`include "dual_bounded_member_set_assert.svh"
module dual_bounded_member_set #(
  parameter int FRIEND_DEPTH = dbms_pkg::DEF_FRIEND_DEPTH,
  parameter int BLOCK_DEPTH  = dbms_pkg::DEF_BLOCK_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [dbms_pkg::CMD_W-1:0]    command,
  input  wire logic                          which_list,
  input  wire logic [dbms_pkg::ID_W-1:0]     member_id,
  input  wire logic [dbms_pkg::POS_W-1:0]    position,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [dbms_pkg::ST_W-1:0]          status,
  output logic [dbms_pkg::ID_W-1:0]          read_value,
  output logic [dbms_pkg::CNT_OUT_W-1:0]     list_count
);

  dbms_pkg::req_t req;
  logic           req_valid;
  logic           req_take;

  dbms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .which_list (which_list),
    .member_id  (member_id),
    .position   (position),
    .req        (req),
    .req_valid  (req_valid),
    .req_take   (req_take)
  );

  dbms_back #(
    .FRIEND_DEPTH (FRIEND_DEPTH),
    .BLOCK_DEPTH  (BLOCK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .req_valid  (req_valid),
    .req_take   (req_take),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .read_value (read_value),
    .list_count (list_count)
  );

  `DBMS_ASSERT_NOW(a_take_needs_word, !req_take || req_valid, "request taken from empty queue")
  `DBMS_ASSERT_IMP(a_take_slot_free, req_take, empty, "request taken while result waits")
  `DBMS_ASSERT_IMP(a_reject_no_value, !empty && status != dbms_pkg::ST_OK, read_value == '0, "value on rejected word")

endmodule
`default_nettype wire
